@@ rtl/igtp_pkg.sv @@
// Package for the integer grid text parser: sizes, codes, character constants,
// and the state, result and result-bundle types used by the other RTL files.
// No dependencies.
package igtp_pkg;

   localparam int MAX_COLUMNS = 4096;
   localparam int MAX_ROWS    = 4096;

   // counters must hold the limit itself
   localparam int COL_W = $clog2(MAX_COLUMNS + 1);
   localparam int ROW_W = $clog2(MAX_ROWS + 1);

   localparam int MODE_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int VALUE_W  = 32;
   localparam int ROW_O_W  = 12;
   localparam int COL_O_W  = 12;
   localparam int MAP_W    = 13;

   localparam int MAX_RESULTS = 3;
   localparam int CNT_W       = 2;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   typedef enum logic [MODE_W-1:0] {
      MODE_CHAR = 2'd0,
      MODE_EOL  = 2'd1,
      MODE_EOF  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_VALUE = 2'd0,
      KIND_LINE  = 2'd1,
      KIND_FILE  = 2'd2,
      KIND_FAIL  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_BAD_CHAR   = 3'd1,
      ERR_EMPTY_LINE = 3'd2,
      ERR_WIDTH      = 3'd3,
      ERR_EMPTY_FILE = 3'd4,
      ERR_SIZE       = 3'd5
   } err_type;

   typedef enum logic [1:0] {
      PH_BETWEEN = 2'd0,
      PH_NUMBER  = 2'd1,
      PH_SKIP    = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic               negative;
      logic [VALUE_W-1:0] acc;
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   width;
      logic               failed;
      logic               line_open;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase: PH_BETWEEN, negative: 1'b0, acc: '0, col: '0, row: '0,
      width: '0, failed: 1'b0, line_open: 1'b0};

   typedef struct packed {
      kind_type           kind;
      logic [VALUE_W-1:0] value;
      logic [ROW_O_W-1:0] row;
      logic [COL_O_W-1:0] column;
      err_type            code;
      logic [MAP_W-1:0]   map_width;
      logic [MAP_W-1:0]   map_height;
   } result_type;

   // all results caused by one input item
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] item;
      logic [CNT_W-1:0]             count;
   } bundle_type;

endpackage

@@ rtl/igtp_core.sv @@
// Parser state register and the combinational update for one input item.
// Produces the bundle of up to three results. Depends on igtp_pkg.
module igtp_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        commit,
   input  igtp_pkg::mode_type          item_mode,
   input  logic [igtp_pkg::CHAR_W-1:0] item_char,
   output igtp_pkg::bundle_type        bundle
);
   import igtp_pkg::*;

   state_type state_ff;
   state_type state_in;

   function automatic result_type make_result(kind_type k, logic [VALUE_W-1:0] v,
                                              logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                              err_type e, logic [COL_W-1:0] mw,
                                              logic [ROW_W-1:0] mh);
      result_type x;
      x.kind       = k;
      x.value      = v;
      x.row        = ROW_O_W'(r);
      x.column     = COL_O_W'(c);
      x.code       = e;
      x.map_width  = MAP_W'(mw);
      x.map_height = MAP_W'(mh);
      return x;
   endfunction

   function automatic void emit(inout bundle_type b, input result_type r);
      b.item[b.count] = r;
      b.count         = b.count + CNT_W'(1);
   endfunction

   function automatic void fail(inout state_type s, inout bundle_type b, input err_type e);
      emit(b, make_result(KIND_FAIL, '0, s.row, s.col, e, '0, '0));
      s.failed = 1'b1;
   endfunction

   function automatic void clear_token(inout state_type s);
      s.phase    = PH_BETWEEN;
      s.negative = 1'b0;
      s.acc      = '0;
   endfunction

   function automatic void finish_token(inout state_type s, inout bundle_type b);
      logic [VALUE_W-1:0] v;
      v = s.negative ? (VALUE_W'(0) - s.acc) : s.acc;
      if (s.phase != PH_BETWEEN) begin
         if (s.col >= COL_W'(MAX_COLUMNS) || s.row >= ROW_W'(MAX_ROWS)) begin
            fail(s, b, ERR_SIZE);
         end else begin
            emit(b, make_result(KIND_VALUE, v, s.row, s.col, ERR_NONE, '0, '0));
            s.col = s.col + COL_W'(1);
            clear_token(s);
         end
      end
   endfunction

   function automatic void end_line(inout state_type s, inout bundle_type b);
      finish_token(s, b);
      if (!s.failed) begin
         if (s.col == '0) begin
            fail(s, b, ERR_EMPTY_LINE);
         end else if (s.width != '0 && s.col != s.width) begin
            fail(s, b, ERR_WIDTH);
         end else begin
            if (s.width == '0) begin
               s.width = s.col;
            end
            emit(b, make_result(KIND_LINE, '0, s.row, '0, ERR_NONE, s.width, '0));
            s.row       = s.row + ROW_W'(1);
            s.col       = '0;
            s.line_open = 1'b0;
            clear_token(s);
         end
      end
   endfunction

   always_comb begin : update
      state_type   s;
      bundle_type  b;
      logic        is_digit;
      logic        legal;
      logic [3:0]  dig;
      s        = state_ff;
      b        = '0;
      is_digit = (item_char >= CHAR_ZERO) && (item_char <= CHAR_NINE);
      legal    = is_digit || item_char == CHAR_SPACE || item_char == CHAR_MINUS
                 || item_char == CHAR_COMMA;
      dig      = 4'(item_char - CHAR_ZERO);
      case (item_mode)
         MODE_CHAR: begin
            if (!s.failed) begin
               if (!legal) begin
                  fail(s, b, ERR_BAD_CHAR);
               end else begin
                  s.line_open = 1'b1;
                  if (item_char == CHAR_SPACE) begin
                     finish_token(s, b);
                  end else begin
                     case (s.phase)
                        PH_BETWEEN: begin
                           if (is_digit) begin
                              s.acc   = VALUE_W'(dig);
                              s.phase = PH_NUMBER;
                           end else if (item_char == CHAR_MINUS) begin
                              s.negative = 1'b1;
                              s.phase    = PH_NUMBER;
                           end else begin
                              s.phase = PH_SKIP;
                           end
                        end
                        PH_NUMBER: begin
                           // times ten as two shifts and an add
                           if (is_digit) begin
                              s.acc = (s.acc << 3) + (s.acc << 1) + VALUE_W'(dig);
                           end else begin
                              s.phase = PH_SKIP;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
         end
         MODE_EOL: begin
            if (!s.failed) begin
               end_line(s, b);
            end
         end
         MODE_EOF: begin
            if (!s.failed) begin
               if (s.line_open || s.phase != PH_BETWEEN) begin
                  end_line(s, b);
               end
               if (!s.failed) begin
                  if (s.row == '0) begin
                     fail(s, b, ERR_EMPTY_FILE);
                  end else begin
                     emit(b, make_result(KIND_FILE, '0, '0, '0, ERR_NONE, s.width, s.row));
                  end
               end
            end
            s = STATE_RESET;
         end
         default: ;
      endcase
      state_in = s;
      bundle   = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (commit) begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/igtp_rsp_buf.sv @@
// Result register: holds one item's bundle and hands it out one beat a cycle while rsp_ready is high.
// Depends on igtp_pkg.
module igtp_rsp_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  igtp_pkg::bundle_type bundle,
   input  logic                 rsp_ready,
   output logic                 free,
   output logic                 rsp_valid,
   output igtp_pkg::result_type result,
   output logic                 rsp_last
);
   import igtp_pkg::*;

   bundle_type       bun_ff;
   logic             valid_ff;
   logic [CNT_W-1:0] idx_ff;
   logic             fire;

   assign rsp_valid = valid_ff;
   assign result    = bun_ff.item[idx_ff];
   assign rsp_last  = (idx_ff == bun_ff.count - CNT_W'(1));
   assign fire      = valid_ff && rsp_ready;
   assign free      = !valid_ff || (fire && rsp_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (fire) begin
         if (rsp_last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bun_ff <= bundle;
      end
   end

endmodule

@@ rtl/integer_grid_text_parser_top.sv @@
// Top level of the integer grid text parser: input register, parser core and
// result register. Depends on igtp_pkg, igtp_core and igtp_rsp_buf.
//
//   channel | ports                                   | role
//   --------+-----------------------------------------+------------------------------
//   req     | req_valid req_ready req_mode             | one beat per character,
//           | req_char_code                            | end of line or end of file
//   rsp     | rsp_valid rsp_ready rsp_kind rsp_value   | one beat per result, 0 to 3
//           | rsp_row rsp_column rsp_error_code        | per request; rsp_last marks
//           | rsp_map_width rsp_map_height rsp_last    | the last one of a request
//
// A request is registered in the input register at accept and parsed by the
// core once the result register can take its results, which then show on rsp.
// Throughput is one request per cycle with rsp_ready high and at most one result each;
// a request with k results holds the result register for k rsp beats, and an
// end of file can yield three (value, line accepted, file accepted).
// Requests that yield no result pass even while the result register is busy.
// Reset is synchronous and clears parser state and both valid flags.
// Stalls on rsp back up into req_ready through the input register.
module integer_grid_text_parser_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [igtp_pkg::MODE_W-1:0]   req_mode,
   input  logic [igtp_pkg::CHAR_W-1:0]   req_char_code,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_kind,
   output logic signed [igtp_pkg::VALUE_W-1:0] rsp_value,
   output logic [igtp_pkg::ROW_O_W-1:0]  rsp_row,
   output logic [igtp_pkg::COL_O_W-1:0]  rsp_column,
   output logic [2:0]                    rsp_error_code,
   output logic [igtp_pkg::MAP_W-1:0]    rsp_map_width,
   output logic [igtp_pkg::MAP_W-1:0]    rsp_map_height,
   output logic                          rsp_last
);
   import igtp_pkg::*;

   // input register
   logic              in_v_ff;
   mode_type          in_mode_ff;
   logic [CHAR_W-1:0] in_char_ff;

   bundle_type bundle;
   result_type result;
   logic       buf_free;
   logic       advance;   // parse the held request this cycle
   logic       load;      // it yields results: move them to the result register

   assign advance   = in_v_ff && (bundle.count == '0 || buf_free);
   assign load      = advance && bundle.count != '0;
   assign req_ready = !in_v_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_v_ff <= 1'b1;
      end else if (advance) begin
         in_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff <= mode_type'(req_mode);
         in_char_ff <= req_char_code;
      end
   end

   igtp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .commit    (advance),
      .item_mode (in_mode_ff),
      .item_char (in_char_ff),
      .bundle    (bundle)
   );

   igtp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .bundle    (bundle),
      .rsp_ready (rsp_ready),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .result    (result),
      .rsp_last  (rsp_last)
   );

   assign rsp_kind       = result.kind;
   assign rsp_value      = $signed(result.value);
   assign rsp_row        = result.row;
   assign rsp_column     = result.column;
   assign rsp_error_code = result.code;
   assign rsp_map_width  = result.map_width;
   assign rsp_map_height = result.map_height;

   // a failure or a file accepted is always the final result of its request
   a_fail_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_FAIL || rsp_kind == KIND_FILE)) |-> rsp_last)
      else $error("failure or file result not last of its request");

   // error code is set exactly on failures
   a_code_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_FAIL) == (rsp_error_code != ERR_NONE)))
      else $error("error code does not match result kind");

   // results only ever enter an empty or draining result register
   a_load_free : assert property (@(posedge clock) disable iff (reset)
      load |-> buf_free)
      else $error("result register overwritten");

   // a held request that is not parsed stays held
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (in_v_ff && !advance) |=> in_v_ff)
      else $error("pending request dropped");

endmodule
